[rtl/rsta_pkg.sv]
// ----------------------------------------------------------------------------
// rsta_pkg : shared types and constants for the RSSI slot table
// Slot count, vector length, transaction structs, codes and FSM states.
// ----------------------------------------------------------------------------
package rsta_pkg;

  localparam int SLOT_COUNT    = 8;
  localparam int VECTOR_LENGTH = 8;
  localparam int IDX_W         = $clog2(SLOT_COUNT);
  localparam int VEC_IW        = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
  localparam int SLOT_W        = 4;

  localparam logic [SLOT_W-1:0] SLOT_NONE         = SLOT_W'(SLOT_COUNT);
  localparam logic [15:0]       AUDIT_ID          = 16'hFFFF;
  localparam logic [15:0]       AUDIT_TIMEOUT_RST = 16'd30;

  typedef enum logic [1:0] {
    MODE_FIND  = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_FLUSH = 2'd2,
    MODE_AUDIT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_FINAL  = 1'b1;

  typedef struct packed {
    logic [1:0]        mode;
    logic [15:0]       tag_id;
    logic [15:0]       timeout;
    logic [15:0]       now;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       reference;
    logic [2:0]        burst_slot;
    logic [7:0]        rssi;
    logic              send;
  } request_t;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot_index;
    logic [15:0]       entry_tag;
    logic [15:0]       entry_reference;
    logic [63:0]       rssi_vector;
    status_t           status;
    logic              last;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_WRITE,
    S_FLUSH,
    S_FINAL
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    latch;
    logic    idx_clear;
    logic    idx_load;
    logic    idx_inc;
    logic    report;
    logic    clear_entry;
    logic    write_entry;
    logic    final_res;
    logic    fin_none;
    status_t fin_status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  slot_over;
    logic  slot_eq;
    logic  slot_ge;
    logic  idx_last;
    logic  idx_end;
    logic  hit;
    logic  aged;
    logic  occupied;
    logic  send;
  } dp_status_t;

endpackage

[rtl/rsta_ctrl.sv]
// ----------------------------------------------------------------------------
// rsta_ctrl : sequencing state machine
// Walks each transaction through dispatch, slot scan, write/flush and the
// final status, driving the datapath with one command word per cycle.
// ----------------------------------------------------------------------------
module rsta_ctrl import rsta_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t sts,
  output dp_cmd_t    cmd,
  output logic       busy
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (sts.mode)
          MODE_FIND, MODE_AUDIT: state_next = S_SCAN;
          MODE_LOAD: begin
            if (sts.slot_over)    state_next = S_IDLE;
            else if (sts.slot_eq) state_next = S_SCAN;
            else                  state_next = S_WRITE;
          end
          MODE_FLUSH: begin
            if (sts.slot_ge) state_next = S_IDLE;
            else             state_next = S_FLUSH;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (sts.hit || sts.idx_last) begin
          state_next = (sts.mode == MODE_LOAD) ? S_WRITE : S_FINAL;
        end
      end
      S_WRITE: begin
        state_next = sts.idx_end ? S_IDLE : S_FINAL;
      end
      S_FLUSH: state_next = S_FINAL;
      S_FINAL: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.latch = start;
      end
      S_DISPATCH: begin
        unique case (sts.mode)
          MODE_FIND, MODE_AUDIT: cmd.idx_clear = 1'b1;
          MODE_LOAD: begin
            if (sts.slot_over) begin
              cmd.final_res  = 1'b1;
              cmd.fin_none   = 1'b1;
              cmd.fin_status = ST_NOT_FOUND;
            end else if (sts.slot_eq) begin
              cmd.idx_clear = 1'b1;
            end else begin
              cmd.idx_load = 1'b1;
            end
          end
          MODE_FLUSH: begin
            if (sts.slot_ge) begin
              cmd.final_res  = 1'b1;
              cmd.fin_none   = 1'b1;
              cmd.fin_status = ST_NOT_FOUND;
            end else begin
              cmd.idx_load = 1'b1;
            end
          end
          default: cmd = '0;
        endcase
      end
      S_SCAN: begin
        if (!sts.hit) begin
          cmd.idx_inc = 1'b1;
          if (sts.aged) begin
            cmd.report      = 1'b1;
            cmd.clear_entry = 1'b1;
          end
        end
      end
      S_WRITE: begin
        if (sts.idx_end) begin
          cmd.final_res  = 1'b1;
          cmd.fin_status = ST_FULL;
        end else begin
          cmd.write_entry = 1'b1;
        end
      end
      S_FLUSH: begin
        if (sts.occupied) begin
          cmd.report      = sts.send;
          cmd.clear_entry = 1'b1;
        end
      end
      S_FINAL: begin
        cmd.final_res  = 1'b1;
        cmd.fin_status = sts.idx_end ? ST_NOT_FOUND : ST_OK;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/rsta_dp.sv]
// ----------------------------------------------------------------------------
// rsta_dp : slot table storage and result path
// Holds the latched transaction, the slot stores, the scan index, the audit
// timeout register and the registered result output.
// ----------------------------------------------------------------------------
module rsta_dp import rsta_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  request_t    request,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  dp_cmd_t     cmd,
  output dp_status_t  sts,
  output logic        result_strobe,
  output result_t     result
);

  typedef logic [VECTOR_LENGTH-1:0][7:0] rssi_row_t;

  request_t           req;
  logic [15:0]        key_id;
  logic [15:0]        key_tout;
  logic [SLOT_W-1:0]  idx;
  logic [15:0]        audit_timeout;

  logic [15:0]        tag_store  [SLOT_COUNT];
  logic [15:0]        ref_store  [SLOT_COUNT];
  logic [15:0]        time_store [SLOT_COUNT];
  rssi_row_t          rssi_store [SLOT_COUNT];

  logic [IDX_W-1:0]   ia;
  logic [15:0]        cur_tag;
  logic [15:0]        age;

  // audit timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      audit_timeout <= AUDIT_TIMEOUT_RST;
    end else if (cfg_we) begin
      audit_timeout <= cfg_wdata;
    end
  end

  // latched transaction and scan key
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= request;
      unique case (mode_t'(request.mode))
        MODE_FIND: begin
          key_id   <= request.tag_id;
          key_tout <= request.timeout;
        end
        MODE_AUDIT: begin
          key_id   <= AUDIT_ID;
          key_tout <= audit_timeout;
        end
        default: begin
          key_id   <= '0;
          key_tout <= '0;
        end
      endcase
    end
  end

  // slot index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_load) begin
      idx <= req.slot;
    end else if (cmd.idx_inc) begin
      idx <= idx + SLOT_W'(1);
    end
  end

  assign ia      = idx[IDX_W-1:0];
  assign cur_tag = tag_store[ia];
  assign age     = req.now - time_store[ia];

  // status to controller
  always_comb begin
    sts.mode      = mode_t'(req.mode);
    sts.slot_over = req.slot > SLOT_NONE;
    sts.slot_eq   = req.slot == SLOT_NONE;
    sts.slot_ge   = req.slot >= SLOT_NONE;
    sts.idx_last  = idx == SLOT_W'(SLOT_COUNT - 1);
    sts.idx_end   = idx == SLOT_NONE;
    sts.hit       = cur_tag == key_id;
    sts.aged      = (cur_tag != '0) && (key_tout != '0) && (age > key_tout);
    sts.occupied  = cur_tag != '0;
    sts.send      = req.send;
  end

  // slot stores: reset frees every slot; else clear, load or evict one slot per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
        tag_store[s]  <= '0;
        ref_store[s]  <= '0;
        time_store[s] <= '0;
        rssi_store[s] <= '0;
      end
    end else if (cmd.clear_entry) begin
      tag_store[ia]  <= '0;
      ref_store[ia]  <= '0;
      time_store[ia] <= '0;
      rssi_store[ia] <= '0;
    end else if (cmd.write_entry) begin
      tag_store[ia]  <= req.tag_id;
      ref_store[ia]  <= req.reference;
      time_store[ia] <= req.now;
      if ({1'b0, req.burst_slot} < 4'(VECTOR_LENGTH)) begin
        rssi_store[ia][req.burst_slot[VEC_IW-1:0]] <= req.rssi;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.report | cmd.final_res;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      result.kind            <= KIND_REPORT;
      result.slot_index      <= idx;
      result.entry_tag       <= cur_tag;
      result.entry_reference <= ref_store[ia];
      result.rssi_vector     <= 64'(rssi_store[ia]);
      result.status          <= ST_OK;
      result.last            <= 1'b0;
    end else if (cmd.final_res) begin
      result.kind            <= KIND_FINAL;
      result.slot_index      <= cmd.fin_none ? SLOT_NONE : idx;
      result.entry_tag       <= '0;
      result.entry_reference <= '0;
      result.rssi_vector     <= '0;
      result.status          <= cmd.fin_status;
      result.last            <= 1'b1;
    end
  end

endmodule

[rtl/rssi_slot_table_with_aging_top.sv]
// Results are registered and appear the cycle after the one that issues them.
// A new transaction is accepted only while busy is low, after the last one ends.
// Find/audit: dispatch, slot scan to a hit or the last slot, final; an allocating
// load scans, then writes or reports full. Direct load and flush: dispatch, write
// or flush, final; an out-of-range slot ends at dispatch. Results cannot stall.
// Reset (synchronous) frees every slot at once and sets the audit timeout to 30.
// ----------------------------------------------------------------------------
// rssi_slot_table_with_aging_top : RSSI slot table with aging
// Slot table with find, load, flush and audit, evicting aged entries on scan.
// ----------------------------------------------------------------------------
module rssi_slot_table_with_aging_top import rsta_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  request_t    request,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        result_strobe,
  output result_t     result
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  // sequencer
  rsta_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // storage and result path
  rsta_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .request       (request),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .sts           (sts),
    .result_strobe (result_strobe),
    .result        (result)
  );

`ifndef ASSERT_OFF
  // an accepted transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // every result is issued while a transaction is in progress
  a_result_in_txn: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy))
    else $error("result issued outside a transaction");

  // an entry report is never the last result and carries status zero
  a_report_form: assert property (@(posedge clk) disable iff (rst)
    result_strobe && (result.kind == KIND_REPORT) |->
      !result.last && (result.status == ST_OK))
    else $error("malformed entry report");

  // the final status closes the transaction: the block is idle meanwhile
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.last |-> !busy)
    else $error("final status while still busy");
`endif

endmodule

[tb/rssi_slot_table_with_aging_top_tb.sv]
// ----------------------------------------------------------------------------
// rssi_slot_table_with_aging_top_tb : self-checking bench for the slot table
// Drives find, load, flush and audit transactions, with random sender gaps,
// into the table. Every result is checked against an in-bench model of the
// slots: ids, references, timestamps and RSSI bytes, aged on each scan.
// ----------------------------------------------------------------------------
module rssi_slot_table_with_aging_top_tb;
  import rsta_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int MAX_REPORTS    = 10;
  localparam int POOL_SIZE      = 10;

  typedef struct {
    request_t          req;
    bit                typed;
    logic [SLOT_W-1:0] want_slot;
    status_t           want_status;
  } directed_row_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  logic        busy;
  request_t    request   = '0;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        result_strobe;
  result_t     result;

  // model of the slot table
  logic [15:0] slot_tag   [SLOT_COUNT];
  logic [15:0] slot_ref   [SLOT_COUNT];
  logic [15:0] slot_stamp [SLOT_COUNT];
  logic [7:0]  slot_rssi  [SLOT_COUNT][VECTOR_LENGTH];
  logic [15:0] audit_age_limit;

  result_t     expected_results [$];
  int          mismatches = 0;
  logic [15:0] tag_pool [POOL_SIZE];
  logic [15:0] wall_now;

  rssi_slot_table_with_aging_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_strobe(result_strobe),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model --

  function automatic void free_slot(int s);
    slot_tag[s]   = 16'd0;
    slot_ref[s]   = 16'd0;
    slot_stamp[s] = 16'd0;
    for (int k = 0; k < VECTOR_LENGTH; k++) slot_rssi[s][k] = 8'd0;
  endfunction

  function automatic logic [63:0] rssi_bytes(int s);
    logic [63:0] v;
    v = '0;
    for (int k = 0; k < VECTOR_LENGTH; k++) v[8*k +: 8] = slot_rssi[s][k];
    return v;
  endfunction

  function automatic void push_eviction(int s);
    result_t r;
    r.kind            = KIND_REPORT;
    r.slot_index      = SLOT_W'(s);
    r.entry_tag       = slot_tag[s];
    r.entry_reference = slot_ref[s];
    r.rssi_vector     = rssi_bytes(s);
    r.status          = ST_OK;
    r.last            = 1'b0;
    expected_results.push_back(r);
  endfunction

  function automatic void push_status(int s, status_t st);
    result_t r;
    r                 = '0;
    r.kind            = KIND_FINAL;
    r.slot_index      = SLOT_W'(s);
    r.status          = st;
    r.last            = 1'b1;
    expected_results.push_back(r);
  endfunction

  // walk the slots up to the first holding id, evicting aged entries passed
  function automatic int scan_slots(logic [15:0] id, logic [15:0] age_limit,
                                    logic [15:0] at);
    int          i;
    logic [15:0] age;
    i = 0;
    while (i < SLOT_COUNT && slot_tag[i] != id) begin
      age = at - slot_stamp[i];
      if (slot_tag[i] != 16'd0 && age_limit != 16'd0 && age > age_limit) begin
        push_eviction(i);
        free_slot(i);
      end
      i++;
    end
    return i;
  endfunction

  function automatic void predict_request(request_t r);
    int s;
    s = int'(r.slot);
    case (r.mode)
      MODE_FIND, MODE_AUDIT: begin
        if (r.mode == MODE_FIND) s = scan_slots(r.tag_id, r.timeout, r.now);
        else s = scan_slots(AUDIT_ID, audit_age_limit, r.now);
        push_status(s, (s < SLOT_COUNT) ? ST_OK : ST_NOT_FOUND);
      end
      MODE_LOAD: begin
        if (s > SLOT_COUNT) begin
          push_status(SLOT_COUNT, ST_NOT_FOUND);
        end else begin
          if (s == SLOT_COUNT) s = scan_slots(16'd0, 16'd0, r.now);
          if (s >= SLOT_COUNT) begin
            push_status(SLOT_COUNT, ST_FULL);
          end else begin
            slot_tag[s]   = r.tag_id;
            slot_ref[s]   = r.reference;
            slot_stamp[s] = r.now;
            if (int'(r.burst_slot) < VECTOR_LENGTH) slot_rssi[s][r.burst_slot] = r.rssi;
            push_status(s, ST_OK);
          end
        end
      end
      default: begin
        if (s >= SLOT_COUNT) begin
          push_status(SLOT_COUNT, ST_NOT_FOUND);
        end else begin
          if (slot_tag[s] != 16'd0) begin
            if (r.send) push_eviction(s);
            free_slot(s);
          end
          push_status(s, ST_OK);
        end
      end
    endcase
  endfunction

  // -------------------------------------------------------------- checking --

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want)
      note_failure($sformatf("%s expected %0h got %0h", field, want, got));
  endfunction

  // results cannot be held off, so each strobe is one accepted result
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_strobe === 1'b1) begin
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result, slot %0d status %0d",
                               result.slot_index, result.status));
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 64'(want.kind), 64'(result.kind));
        check_field("slot_index", 64'(want.slot_index), 64'(result.slot_index));
        check_field("entry_tag", 64'(want.entry_tag), 64'(result.entry_tag));
        check_field("entry_reference", 64'(want.entry_reference),
                    64'(result.entry_reference));
        check_field("rssi_vector", want.rssi_vector, result.rssi_vector);
        check_field("status", 64'(want.status), 64'(result.status));
        check_field("last", 64'(want.last), 64'(result.last));
      end
    end
  end

  // ends the run if nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start === 1'b1 && busy === 1'b0) || result_strobe === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // ------------------------------------------------------------- stimulus --

  // hold the transaction until the block takes it, then update the model
  task automatic issue(input request_t r);
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_request(r);
  endtask

  task automatic pace_sender(input int idle_pct);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_audit_limit(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    audit_age_limit = value;
    cfg_we    <= 1'b0;
  endtask

  function automatic directed_row_t step_row(
      mode_t m, logic [15:0] tag, logic [15:0] tout, logic [15:0] at,
      logic [SLOT_W-1:0] slot, logic [15:0] ref_word, logic [2:0] burst,
      logic [7:0] level, logic send, bit typed,
      logic [SLOT_W-1:0] want_slot, status_t want_status);
    directed_row_t row;
    row.req             = '0;
    row.req.mode        = m;
    row.req.tag_id      = tag;
    row.req.timeout     = tout;
    row.req.now         = at;
    row.req.slot        = slot;
    row.req.reference   = ref_word;
    row.req.burst_slot  = burst;
    row.req.rssi        = level;
    row.req.send        = send;
    row.typed           = typed;
    row.want_slot       = want_slot;
    row.want_status     = want_status;
    return row;
  endfunction

  // random transaction: mostly pooled ids and a slowly moving clock so that
  // finds hit and entries age, with some fully random values mixed in
  function automatic request_t random_request();
    request_t    r;
    logic [95:0] noise;
    int          pick;
    noise = {$urandom(), $urandom(), $urandom()};
    r     = noise[$bits(request_t)-1:0];
    pick  = $urandom_range(99);
    if (pick < 40)      r.mode = MODE_LOAD;
    else if (pick < 70) r.mode = MODE_FIND;
    else if (pick < 85) r.mode = MODE_FLUSH;
    else                r.mode = MODE_AUDIT;

    pick = $urandom_range(99);
    if (pick < 70)      r.tag_id = tag_pool[$urandom_range(POOL_SIZE-1)];
    else if (pick < 80) r.tag_id = 16'd0;

    wall_now = wall_now + 16'($urandom_range(12));
    if ($urandom_range(99) >= 15) r.now = wall_now;

    pick = $urandom_range(99);
    if (pick < 10)      r.timeout = 16'd0;
    else if (pick < 70) r.timeout = 16'($urandom_range(1, 60));

    pick = $urandom_range(99);
    if (r.mode == MODE_LOAD) begin
      if (pick < 45)      r.slot = SLOT_W'($urandom_range(SLOT_COUNT-1));
      else if (pick < 85) r.slot = SLOT_NONE;
      else                r.slot = SLOT_W'($urandom_range(SLOT_COUNT+1, 15));
    end else if (pick < 85) begin
      r.slot = SLOT_W'($urandom_range(SLOT_COUNT-1));
    end
    return r;
  endfunction

  task automatic run_random(input int count, input int idle_pct);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 3) drain_results();
      else pace_sender(idle_pct);
      issue(random_request());
    end
    drain_results();
  endtask

  // ----------------------------------------------------------------- main --

  initial begin : main
    directed_row_t plan [$];
    result_t       fixed;

    audit_age_limit = AUDIT_TIMEOUT_RST;
    for (int s = 0; s < SLOT_COUNT; s++) free_slot(s);
    tag_pool[0] = AUDIT_ID;
    for (int i = 1; i < POOL_SIZE; i++) tag_pool[i] = 16'($urandom_range(1, 65535));
    wall_now = 16'($urandom);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty table: nothing found, then id 0 hits the first free slot
    plan.push_back(step_row(MODE_FIND, 16'h1234, 16'd5, 16'd0, 4'd0, 16'd0, 3'd0,
                            8'd0, 1'b0, 1'b1, SLOT_NONE, ST_NOT_FOUND));
    plan.push_back(step_row(MODE_FIND, 16'd0, 16'd0, 16'd0, 4'd0, 16'd0, 3'd0,
                            8'd0, 1'b0, 1'b1, 4'd0, ST_OK));
    // fill every slot, each with its own RSSI position
    for (int i = 0; i < SLOT_COUNT; i++)
      plan.push_back(step_row(MODE_LOAD,
                              (i == 0) ? 16'h0001 : (i == 1) ? AUDIT_ID :
                              (i == 7) ? 16'h8000 : 16'(16'h0100 + i),
                              16'hFFFF, (i == 0) ? 16'hFFFF : 16'(1000 + 10*i),
                              SLOT_W'(i), (i == 0) ? 16'hFFFF : 16'(16'h1111 * i),
                              3'(i), (i == 0) ? 8'hFF : 8'(8'h21 * i), 1'b1,
                              1'b1, SLOT_W'(i), ST_OK));
    // full table, and slots out of range
    plan.push_back(step_row(MODE_LOAD, 16'h4444, 16'd0, 16'd1100, SLOT_NONE, 16'h5555,
                            3'd2, 8'h44, 1'b0, 1'b1, SLOT_NONE, ST_FULL));
    plan.push_back(step_row(MODE_LOAD, 16'h4444, 16'd0, 16'd1100, 4'd9, 16'h5555,
                            3'd2, 8'h44, 1'b0, 1'b1, SLOT_NONE, ST_NOT_FOUND));
    plan.push_back(step_row(MODE_FLUSH, 16'd0, 16'd0, 16'd0, SLOT_NONE, 16'd0,
                            3'd0, 8'd0, 1'b1, 1'b1, SLOT_NONE, ST_NOT_FOUND));
    plan.push_back(step_row(MODE_FLUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 16'hFFFF,
                            3'd7, 8'hFF, 1'b1, 1'b1, SLOT_NONE, ST_NOT_FOUND));
    // no eviction with timeout zero or the largest timeout
    plan.push_back(step_row(MODE_FIND, 16'h8000, 16'd0, 16'd1100, 4'd0, 16'd0,
                            3'd0, 8'd0, 1'b0, 1'b1, 4'd7, ST_OK));
    plan.push_back(step_row(MODE_FIND, 16'h8000, 16'hFFFF, 16'd1100, 4'd0, 16'd0,
                            3'd0, 8'd0, 1'b0, 1'b1, 4'd7, ST_OK));
    // aged entries evicted before the hit, one of them by a wrapped age
    plan.push_back(step_row(MODE_FIND, 16'h0106, 16'd50, 16'd1080, 4'd0, 16'd0,
                            3'd0, 8'd0, 1'b0, 1'b0, 4'd0, ST_OK));
    // audit with the reset timeout
    plan.push_back(step_row(MODE_AUDIT, 16'd0, 16'd0, 16'd1075, 4'd0, 16'd0,
                            3'd0, 8'd0, 1'b0, 1'b0, 4'd0, ST_OK));
    // flush of a free slot, flush with and without report
    plan.push_back(step_row(MODE_FLUSH, 16'd0, 16'd0, 16'd0, 4'd0, 16'd0,
                            3'd0, 8'd0, 1'b1, 1'b1, 4'd0, ST_OK));
    plan.push_back(step_row(MODE_FLUSH, 16'd0, 16'd0, 16'd0, 4'd5, 16'd0,
                            3'd0, 8'd0, 1'b1, 1'b0, 4'd0, ST_OK));
    plan.push_back(step_row(MODE_FLUSH, 16'd0, 16'd0, 16'd0, 4'd6, 16'd0,
                            3'd0, 8'd0, 1'b0, 1'b0, 4'd0, ST_OK));
    // a load of id 0 leaves the slot free for the next find of id 0
    plan.push_back(step_row(MODE_LOAD, 16'd0, 16'd0, 16'd1200, SLOT_NONE, 16'hABCD,
                            3'd4, 8'h5A, 1'b0, 1'b1, 4'd0, ST_OK));
    plan.push_back(step_row(MODE_FIND, 16'd0, 16'd1, 16'd5000, 4'd0, 16'd0,
                            3'd0, 8'd0, 1'b0, 1'b1, 4'd0, ST_OK));

    foreach (plan[i]) begin
      pace_sender(31);
      issue(plan[i].req);
      if (plan[i].typed) begin
        fixed            = expected_results.pop_back();
        fixed.slot_index = plan[i].want_slot;
        fixed.status     = plan[i].want_status;
        expected_results.push_back(fixed);
      end
    end
    drain_results();

    // random phases over the audit timeout settings
    write_audit_limit(16'd1);
    run_random(110, 31);
    write_audit_limit(16'hFFFF);
    run_random(110, 55);
    write_audit_limit(16'd0);
    run_random(60, 0);
    write_audit_limit(16'($urandom_range(20, 200)));
    run_random(65, 0);

    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
